[design/grid_ray_march_column_unit_assert.svh]
// Assertion macros for the grid ray march column unit.
// Depends on nothing; included inside module bodies that check their own logic.
`ifndef GRID_RAY_MARCH_COLUMN_UNIT_ASSERT_SVH
`define GRID_RAY_MARCH_COLUMN_UNIT_ASSERT_SVH

// Same-cycle implication under synchronous reset
`define GRCU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("grcu: implication check failed");

// Next-cycle implication under synchronous reset
`define GRCU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("grcu: next-cycle check failed");

`endif

[design/grcu_pkg.sv]
// Shared constants and arithmetic helpers for the grid ray march column unit.
// Depends on nothing; imported by grid_ray_march_column_unit.
package grcu_pkg;

   // Default build values
   localparam int DEF_SCREEN_WIDTH  = 178;
   localparam int DEF_SCREEN_HEIGHT = 52;
   localparam int DEF_MAP_SIZE      = 16;
   localparam int DEF_MAX_STEPS     = 160;

   // One cell in march units (640 per 1/256 cell)
   localparam int CELL_UNITS = 163840;

   // Register indexes
   localparam logic [2:0] REG_MAP0    = 3'd0;
   localparam logic [2:0] REG_MAP1    = 3'd1;
   localparam logic [2:0] REG_MAP2    = 3'd2;
   localparam logic [2:0] REG_MAP3    = 3'd3;
   localparam logic [2:0] REG_POS_X   = 3'd4;
   localparam logic [2:0] REG_POS_Y   = 3'd5;
   localparam logic [2:0] REG_HEADING = 3'd6;
   localparam logic [2:0] REG_FOV     = 3'd7;

   // Reset contents
   localparam logic [63:0] MAP0_RESET = 64'd9223933891591602687;
   localparam logic [63:0] MAP1_RESET = 64'd9225483105647821185;
   localparam logic [63:0] MAP2_RESET = 64'd9259819206227099651;
   localparam logic [63:0] MAP3_RESET = 64'd18446603344802840577;
   localparam logic [11:0] POS_RESET  = 12'd2048;
   localparam logic [15:0] HEADING_RESET = 16'd0;
   localparam logic [14:0] FOV_RESET  = 15'd8203;

   // Hit kinds
   localparam logic [1:0] HIT_WALL = 2'd0;
   localparam logic [1:0] HIT_LEFT = 2'd1;
   localparam logic [1:0] HIT_DEPTH = 2'd2;

   // Quarter-wave sine table, Q1.14
   function automatic logic [14:0] sine_entry(input logic [5:0] idx);
      logic [14:0] v;
      case (idx)
         6'd0: v = 15'd0;      6'd1: v = 15'd804;    6'd2: v = 15'd1606;
         6'd3: v = 15'd2404;   6'd4: v = 15'd3196;   6'd5: v = 15'd3981;
         6'd6: v = 15'd4756;   6'd7: v = 15'd5520;   6'd8: v = 15'd6270;
         6'd9: v = 15'd7005;   6'd10: v = 15'd7723;  6'd11: v = 15'd8423;
         6'd12: v = 15'd9102;  6'd13: v = 15'd9760;  6'd14: v = 15'd10394;
         6'd15: v = 15'd11003; 6'd16: v = 15'd11585; 6'd17: v = 15'd12140;
         6'd18: v = 15'd12665; 6'd19: v = 15'd13160; 6'd20: v = 15'd13623;
         6'd21: v = 15'd14053; 6'd22: v = 15'd14449; 6'd23: v = 15'd14811;
         6'd24: v = 15'd15137; 6'd25: v = 15'd15426; 6'd26: v = 15'd15679;
         6'd27: v = 15'd15893; 6'd28: v = 15'd16069; 6'd29: v = 15'd16207;
         6'd30: v = 15'd16305; 6'd31: v = 15'd16364;
         default: v = 15'd16384;
      endcase
      return v;
   endfunction

   // Interpolated quarter wave, f in 0..16384
   function automatic logic [14:0] quarter_sine(input logic [14:0] f);
      logic [5:0]  idx;
      logic [8:0]  frac;
      logic [14:0] base;
      logic [14:0] diff;
      logic [23:0] prod;
      idx  = f[14:9];
      frac = f[8:0];
      base = sine_entry(idx);
      diff = sine_entry(idx + 6'd1) - base;
      prod = 24'(diff) * 24'(frac);
      if (idx >= 6'd32) begin
         return 15'd16384;
      end
      return base + 15'(prod >> 9);
   endfunction

   // Full-turn sine, angle in 2^-16 turn
   function automatic logic signed [15:0] sine_of(input logic [15:0] a);
      logic [14:0] mag;
      logic [14:0] f;
      f = {1'b0, a[13:0]};
      if (a[14]) begin
         mag = quarter_sine(15'd16384 - f);
      end else begin
         mag = quarter_sine(f);
      end
      if (a[15]) begin
         return -$signed({1'b0, mag});
      end
      return $signed({1'b0, mag});
   endfunction

   // Divide a value below 80 by five
   function automatic logic [3:0] div5(input logic [6:0] q);
      logic [16:0] p;
      p = 17'(q) * 17'd205;
      return 4'(p >> 10);
   endfunction

endpackage

[design/grid_ray_march_column_unit.sv]
// Column ray caster over a 16x16 wall grid: top level and whole datapath.
// Depends on grcu_pkg and grid_ray_march_column_unit_assert.svh.
//
// Use: drive req_column_index and raise start while busy is low; the column
// is taken at that edge and busy rises. The block forms the ray angle with a
// reciprocal multiply, reads sine and cosine from a quarter-wave table, then
// marches the ray one tenth of a cell per cycle until a wall, the map edge or
// MAX_STEPS. A bit-serial divider then forms the ceiling row.
// Sequence: the angle state, the sine and cosine table states, the march
// state for each step taken (1..MAX_STEPS steps), the divider state for
// NUM_W quotient bits (23 at the default build) and the done state; busy
// stays high through all of them and the result shows in the last. A new
// column can be taken in the cycle after the result; one column is in
// flight at a time. The result shows on the rsp_ ports for one cycle with
// rsp_valid high; the receiver cannot stall and must take it then. The user
// writes registers through the csr_ port only while busy is low; the block
// itself does not enforce this. Reset returns the sequencer to idle and
// loads the default map, position, heading and field of view.
module grid_ray_march_column_unit #(
   parameter int SCREEN_WIDTH  = grcu_pkg::DEF_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = grcu_pkg::DEF_SCREEN_HEIGHT,
   parameter int MAP_SIZE      = grcu_pkg::DEF_MAP_SIZE,
   parameter int MAX_STEPS     = grcu_pkg::DEF_MAX_STEPS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [7:0]        req_column_index,
   output logic              rsp_valid,
   output logic [7:0]        rsp_column_echo,
   output logic [1:0]        rsp_hit_kind,
   output logic [7:0]        rsp_march_steps,
   output logic signed [9:0] rsp_ceiling_row,
   output logic [9:0]        rsp_floor_row,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_write_data
);
   import grcu_pkg::*;

   `include "grid_ray_march_column_unit_assert.svh"

   localparam int STEP_W = $clog2(MAX_STEPS + 1);
   localparam int DEN_W  = (STEP_W + 1 > 8) ? STEP_W + 1 : 8;
   localparam int NUM_W  = (8 + STEP_W > 23) ? 8 + STEP_W : 23;
   localparam int CNT_W  = $clog2(NUM_W);
   localparam int ACC_W  = 19 + STEP_W;
   localparam int MAP_LIMIT = MAP_SIZE * CELL_UNITS;

   // Reciprocal of the screen width, exact for products below 2^23
   localparam int RECIP_SH = 31;
   localparam logic [31:0] RECIP =
      32'(((64'd1 << RECIP_SH) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ADIV = 3'd1;
   localparam logic [2:0] ST_SINX = 3'd2;
   localparam logic [2:0] ST_SINY = 3'd3;
   localparam logic [2:0] ST_MARCH = 3'd4;
   localparam logic [2:0] ST_CDIV = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [63:0] map0_ff, map1_ff, map2_ff, map3_ff;
   logic [11:0] posx_ff, posy_ff;
   logic [15:0] head_ff;
   logic [14:0] fov_ff;

   logic [7:0]  col_ff, col_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [15:0] angle_ff, angle_in;
   logic signed [15:0] eyex_ff, eyex_in, eyey_ff, eyey_in;
   logic signed [ACC_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [STEP_W-1:0] n_ff, n_in;
   logic [1:0]  kind_ff, kind_in;
   logic        neg_ff, neg_in;

   logic        valid_ff, valid_in;
   logic [7:0]  out_col_ff, out_col_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [7:0]  out_steps_ff, out_steps_in;
   logic signed [9:0] out_ceil_ff, out_ceil_in;
   logic [9:0]  out_floor_ff, out_floor_in;

   // Divider step: restoring, one quotient bit per cycle
   logic [DEN_W:0]   trial;
   logic             take;
   logic [DEN_W-1:0] rem_step;
   logic [NUM_W-1:0] quo_step;
   logic             div_last;

   assign trial    = {rem_ff, quo_ff[NUM_W-1]};
   assign take     = trial >= {1'b0, den_ff};
   assign rem_step = take ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
   assign quo_step = {quo_ff[NUM_W-2:0], take};
   assign div_last = cnt_ff == CNT_W'(NUM_W - 1);

   // Angle offset: column times fov over the screen width
   logic [NUM_W+31:0] angle_prod;
   assign angle_prod = (NUM_W+32)'(quo_ff) * (NUM_W+32)'(RECIP);

   // March step: advance both coordinates and test the cell
   logic signed [ACC_W-1:0] nx, ny;
   logic        offx, offy, wall;
   logic [3:0]  cx, cy;
   logic [255:0] map_all;
   logic [STEP_W-1:0] n_next;

   assign nx = px_ff + {{(ACC_W-16){eyex_ff[15]}}, eyex_ff};
   assign ny = py_ff + {{(ACC_W-16){eyey_ff[15]}}, eyey_ff};
   assign offx = nx[ACC_W-1] || ($unsigned(nx) >= ACC_W'(MAP_LIMIT));
   assign offy = ny[ACC_W-1] || ($unsigned(ny) >= ACC_W'(MAP_LIMIT));
   assign cx = div5(nx[21:15]);
   assign cy = div5(ny[21:15]);
   assign map_all = {map3_ff, map2_ff, map1_ff, map0_ff};
   assign wall = map_all[{cy, cx}];
   assign n_next = n_ff + STEP_W'(1);

   // Shared sine unit
   logic [15:0]        sin_arg;
   logic signed [15:0] sin_val;
   assign sin_arg = (state_ff == ST_SINY) ? angle_ff + 16'd16384 : angle_ff;
   assign sin_val = sine_of(sin_arg);

   // Ceiling setup from the final step count
   logic [STEP_W-1:0] fin_steps, steps_diff;
   logic              fin_neg;
   always_comb begin
      fin_steps = n_next;
      if (offx || offy || (!wall && n_next == STEP_W'(MAX_STEPS))) begin
         fin_steps = STEP_W'(MAX_STEPS);
      end
      fin_neg = fin_steps < STEP_W'(20);
      steps_diff = fin_neg ? STEP_W'(20) - fin_steps : fin_steps - STEP_W'(20);
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      col_in = col_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      angle_in = angle_ff;
      eyex_in = eyex_ff;
      eyey_in = eyey_ff;
      px_in = px_ff;
      py_in = py_ff;
      n_in = n_ff;
      kind_in = kind_ff;
      neg_in = neg_ff;
      valid_in = 1'b0;
      out_col_in = out_col_ff;
      out_kind_in = out_kind_ff;
      out_steps_in = out_steps_ff;
      out_ceil_in = out_ceil_ff;
      out_floor_in = out_floor_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               col_in = req_column_index;
               quo_in = NUM_W'(req_column_index) * NUM_W'(fov_ff);
               state_in = ST_ADIV;
            end
         end
         ST_ADIV: begin
            angle_in = head_ff - 16'(fov_ff >> 1) + angle_prod[RECIP_SH +: 16];
            state_in = ST_SINX;
         end
         ST_SINX: begin
            eyex_in = sin_val;
            state_in = ST_SINY;
         end
         ST_SINY: begin
            eyey_in = sin_val;
            px_in = $signed(ACC_W'({posx_ff, 9'b0}) + ACC_W'({posx_ff, 7'b0}));
            py_in = $signed(ACC_W'({posy_ff, 9'b0}) + ACC_W'({posy_ff, 7'b0}));
            n_in = '0;
            state_in = ST_MARCH;
         end
         ST_MARCH: begin
            px_in = nx;
            py_in = ny;
            n_in = n_next;
            if (offx || offy || wall || n_next == STEP_W'(MAX_STEPS)) begin
               if (offx || offy) begin
                  kind_in = HIT_LEFT;
               end else if (wall) begin
                  kind_in = HIT_WALL;
               end else begin
                  kind_in = HIT_DEPTH;
               end
               n_in = fin_steps;
               neg_in = fin_neg;
               quo_in = NUM_W'(SCREEN_HEIGHT) * NUM_W'(steps_diff);
               rem_in = '0;
               den_in = DEN_W'({fin_steps, 1'b0});
               cnt_in = '0;
               state_in = ST_CDIV;
            end
         end
         ST_CDIV: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_last) begin
               out_col_in = col_ff;
               out_kind_in = kind_ff;
               out_steps_in = 8'(n_ff);
               out_ceil_in = neg_ff ? -$signed(quo_step[9:0]) : $signed(quo_step[9:0]);
               out_floor_in = 10'(SCREEN_HEIGHT) - (neg_ff ? -quo_step[9:0] : quo_step[9:0]);
               valid_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         map0_ff <= MAP0_RESET;
         map1_ff <= MAP1_RESET;
         map2_ff <= MAP2_RESET;
         map3_ff <= MAP3_RESET;
         posx_ff <= POS_RESET;
         posy_ff <= POS_RESET;
         head_ff <= HEADING_RESET;
         fov_ff <= FOV_RESET;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               REG_MAP0: map0_ff <= csr_write_data;
               REG_MAP1: map1_ff <= csr_write_data;
               REG_MAP2: map2_ff <= csr_write_data;
               REG_MAP3: map3_ff <= csr_write_data;
               REG_POS_X: posx_ff <= csr_write_data[11:0];
               REG_POS_Y: posy_ff <= csr_write_data[11:0];
               REG_HEADING: head_ff <= csr_write_data[15:0];
               REG_FOV: fov_ff <= csr_write_data[14:0];
               default: ;
            endcase
         end
      end
   end

   // Advance datapath registers
   always_ff @(posedge clock) begin
      col_ff <= col_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      angle_ff <= angle_in;
      eyex_ff <= eyex_in;
      eyey_ff <= eyey_in;
      px_ff <= px_in;
      py_ff <= py_in;
      n_ff <= n_in;
      kind_ff <= kind_in;
      neg_ff <= neg_in;
      out_col_ff <= out_col_in;
      out_kind_ff <= out_kind_in;
      out_steps_ff <= out_steps_in;
      out_ceil_ff <= out_ceil_in;
      out_floor_ff <= out_floor_in;
   end

   assign busy = state_ff != ST_IDLE;
   assign rsp_valid = valid_ff;
   assign rsp_column_echo = out_col_ff;
   assign rsp_hit_kind = out_kind_ff;
   assign rsp_march_steps = out_steps_ff;
   assign rsp_ceiling_row = out_ceil_ff;
   assign rsp_floor_row = out_floor_ff;

   `GRCU_ASSERT_NEXT(a_take_sets_busy, clock, reset, start && !busy, busy)
   `GRCU_ASSERT_NEXT(a_result_frees, clock, reset, rsp_valid, !busy)
   `GRCU_ASSERT_IMP(a_march_bound, clock, reset, state_ff == ST_MARCH,
      n_ff < STEP_W'(MAX_STEPS))
   `GRCU_ASSERT_IMP(a_result_busy, clock, reset, rsp_valid, busy)

endmodule
